FILE: rtl/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg - status light renderer shared types and constants
// Status codes, base colors, breathing curve and divider reciprocals.
// ----------------------------------------------------------------------------
package slr_pkg;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_THINKING = 3'd1,
		ST_TOOL     = 3'd2,
		ST_OUTPUT   = 3'd3,
		ST_PERMIT   = 3'd4,
		ST_COMPLETE = 3'd5,
		ST_ERROR    = 3'd6,
		ST_NONE     = 3'd7
	} status_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	localparam rgb_t COLOR_OFF   = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
	localparam rgb_t COLOR_RED   = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
	localparam rgb_t COLOR_AMBER = '{red: 8'd255, green: 8'd160, blue: 8'd0};
	localparam rgb_t COLOR_BLUE  = '{red: 8'd0,   green: 8'd96,  blue: 8'd255};
	localparam rgb_t COLOR_GREEN = '{red: 8'd0,   green: 8'd255, blue: 8'd64};

	localparam logic [7:0] LEVEL_FULL = 8'd255;
	localparam logic [7:0] LEVEL_ZERO = 8'd0;
	localparam logic [7:0] LEVEL_ROUND = 8'd255;

	// floor(x/3) = (x * DIV3_MAGIC) >> 33, exact for x < 2^32
	localparam logic [31:0] DIV3_MAGIC = 32'hAAAA_AAAB;
	localparam int unsigned DIV3_SHIFT = 33;
	// floor(x/25) = (x * DIV25_MAGIC) >> 35, exact for x < 2^32
	localparam logic [31:0] DIV25_MAGIC = 32'h51EB_851F;
	localparam int unsigned DIV25_SHIFT = 35;

	function automatic logic [7:0] curve_level(input logic [4:0] idx);
		logic [7:0] lvl;
		unique case (idx)
			5'd0:  lvl = 8'd24;
			5'd1:  lvl = 8'd25;
			5'd2:  lvl = 8'd27;
			5'd3:  lvl = 8'd30;
			5'd4:  lvl = 8'd34;
			5'd5:  lvl = 8'd39;
			5'd6:  lvl = 8'd45;
			5'd7:  lvl = 8'd52;
			5'd8:  lvl = 8'd60;
			5'd9:  lvl = 8'd69;
			5'd10: lvl = 8'd79;
			5'd11: lvl = 8'd90;
			5'd12: lvl = 8'd102;
			5'd13: lvl = 8'd115;
			5'd14: lvl = 8'd129;
			5'd15: lvl = 8'd143;
			5'd16: lvl = 8'd157;
			5'd17: lvl = 8'd171;
			5'd18: lvl = 8'd185;
			5'd19: lvl = 8'd198;
			5'd20: lvl = 8'd210;
			5'd21: lvl = 8'd221;
			5'd22: lvl = 8'd231;
			5'd23: lvl = 8'd239;
			5'd24: lvl = 8'd246;
			5'd25: lvl = 8'd250;
			5'd26: lvl = 8'd253;
			5'd27: lvl = 8'd255;
			5'd28: lvl = 8'd255;
			5'd29: lvl = 8'd253;
			5'd30: lvl = 8'd250;
			5'd31: lvl = 8'd246;
			default: lvl = 8'd0;
		endcase
		return lvl;
	endfunction

	// triangle fold over 64 phases: phase or 63 - phase
	function automatic logic [4:0] fold_phase(input logic [5:0] ph);
		return ph[5] ? ~ph[4:0] : ph[4:0];
	endfunction

endpackage

FILE: rtl/status_light_effect_renderer_unit.sv
// ----------------------------------------------------------------------------
// status_light_effect_renderer_unit - status code to RGB light effect
// Three-stage pipeline: divide, pick level and color, scale.
// ----------------------------------------------------------------------------
// Usage:
//   Drive status_code and time_ms and pulse start; an item transfers on a
//   rising edge with start high and busy low. busy is always low, so one
//   item may transfer every cycle.
//   Each item gives one result: done is high for exactly one cycle with
//   active, red, green and blue valid in that cycle. Results come out in
//   order; an item passes the stage-one, stage-two and stage-three
//   registers in turn, and done is the stage-three valid bit.
//   Throughput is one item per cycle. Stage one holds the reciprocal
//   multiplies for time/12 and time/200, stage two the curve lookup and
//   color select, stage three the 8x8 brightness multiplies.
//   The receiver has no back pressure; done must be sampled when it fires.
//   Reset (arst_n low) clears the valid bits, dropping items in flight.
//   The block keeps no other state.
// ----------------------------------------------------------------------------
module status_light_effect_renderer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  status_code,
	input  logic [31:0] time_ms,
	output logic        done,
	output logic        active,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);
	import slr_pkg::*;

	logic        accept;
	logic [61:0] prod3;
	logic [60:0] prod25;

	logic        valid_s1;
	status_t     code_s1;
	logic [5:0]  slow_ph_s1;
	logic [5:0]  fast_ph_s1;
	logic        blink_odd_s1;

	logic        valid_s2;
	logic        active_s2;
	rgb_t        color_s2;
	logic [7:0]  level_s2;

	logic        active_c;
	rgb_t        color_c;
	logic [7:0]  level_c;
	logic [7:0]  slow_lvl;
	logic [7:0]  fast_lvl;

	logic        active_s3;
	rgb_t        color_s3;

	function automatic logic [61:0] t3_prod(input logic [29:0] x);
		return 62'(x) * 62'(DIV3_MAGIC);
	endfunction

	function automatic logic [60:0] t25_prod(input logic [28:0] x);
		return 61'(x) * 61'(DIV25_MAGIC);
	endfunction

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// time/12 = (time>>2)/3, time/200 = (time>>3)/25
	assign prod3  = t3_prod(time_ms[31:2]);
	assign prod25 = t25_prod(time_ms[31:3]);

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		code_s1      <= status_t'(status_code);
		slow_ph_s1   <= time_ms[10:5];
		fast_ph_s1   <= prod3[DIV3_SHIFT+5:DIV3_SHIFT];
		blink_odd_s1 <= prod25[DIV25_SHIFT];
	end

	// stage 2
	assign slow_lvl = curve_level(fold_phase(slow_ph_s1));
	assign fast_lvl = curve_level(fold_phase(fast_ph_s1));

	always_comb begin
		active_c = 1'b1;
		color_c  = COLOR_OFF;
		level_c  = LEVEL_ZERO;
		unique case (code_s1)
			ST_THINKING: begin
				color_c = COLOR_RED;
				level_c = slow_lvl;
			end
			ST_TOOL: begin
				color_c = COLOR_RED;
				level_c = LEVEL_FULL;
			end
			ST_OUTPUT: begin
				color_c = COLOR_AMBER;
				level_c = slow_lvl;
			end
			ST_PERMIT: begin
				color_c = COLOR_BLUE;
				level_c = fast_lvl;
			end
			ST_COMPLETE: begin
				color_c = COLOR_GREEN;
				level_c = LEVEL_FULL;
			end
			ST_ERROR: begin
				color_c = COLOR_RED;
				level_c = blink_odd_s1 ? LEVEL_ZERO : LEVEL_FULL;
			end
			ST_IDLE, ST_NONE: begin
				active_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		active_s2 <= active_c;
		color_s2  <= color_c;
		level_s2  <= level_c;
	end

	// stage 3
	slr_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s2),
		.active_in (active_s2),
		.color_in  (color_s2),
		.level_in  (level_s2),
		.valid_s3  (done),
		.active_s3 (active_s3),
		.color_s3  (color_s3)
	);

	assign active = active_s3;
	assign red    = color_s3.red;
	assign green  = color_s3.green;
	assign blue   = color_s3.blue;

endmodule

FILE: rtl/slr_scale.sv
// ----------------------------------------------------------------------------
// slr_scale - brightness scaling stage
// Registers (c * level + 255) >> 8 for each channel, with the active flag.
// ----------------------------------------------------------------------------
module slr_scale (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_in,
	input  logic         active_in,
	input  slr_pkg::rgb_t color_in,
	input  logic [7:0]   level_in,
	output logic         valid_s3,
	output logic         active_s3,
	output slr_pkg::rgb_t color_s3
);
	import slr_pkg::*;

	function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] l);
		logic [15:0] sum;
		sum = 16'(c) * 16'(l) + 16'(LEVEL_ROUND);
		return sum[15:8];
	endfunction

	rgb_t scaled;

	always_comb begin
		scaled.red   = scale(color_in.red,   level_in);
		scaled.green = scale(color_in.green, level_in);
		scaled.blue  = scale(color_in.blue,  level_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		active_s3 <= active_in;
		color_s3  <= scaled;
	end

endmodule
